// ===== rtl/roc_auc_trapezoid_core_assert.svh =====
// Assertion macros for the ROC AUC core
`ifndef ROC_AUC_TRAPEZOID_CORE_ASSERT_SVH
`define ROC_AUC_TRAPEZOID_CORE_ASSERT_SVH
// Implication check, disabled while rst_n is low
`define RAT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication check
`define RAT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== rtl/rat_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rat_pkg
// Shared constants and types for the ROC AUC trapezoid core.
// ----------------------------------------------------------------------------
package rat_pkg;
  localparam int Capacity  = 1024;
  localparam int AddrW     = $clog2(Capacity);
  localparam int CntW      = AddrW + 1;
  localparam int ScoreW    = 32;
  localparam int KeyW      = ScoreW + 1;       // order key plus label
  localparam int SumW      = 2 * CntW + 1;
  localparam int AucW      = 17;
  localparam int StatW     = 2;
  localparam int OutCntW   = 11;

  localparam logic [StatW-1:0] ST_OK      = 2'd0;
  localparam logic [StatW-1:0] ST_ONECLS  = 2'd1;
  localparam logic [StatW-1:0] ST_OVERFL  = 2'd2;

  typedef logic [KeyW-1:0] key_t;
endpackage

// ===== rtl/roc_auc_trapezoid_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roc_auc_trapezoid_core
// Stores scored samples, heap-sorts them in RAM and integrates the ROC curve.
// ----------------------------------------------------------------------------
// channel | direction | fields
// in_     | input     | score, label, last
// out_    | output    | auc, status, positives, negatives
//
// A pair is taken whenever in_valid is high and the input is not stalled. On
// the last pair the store is copied into a work RAM, heap-sorted through one
// read port (about n*log2 n sift levels), swept and divided. The input stalls
// during that job and while a result waits.
// Synchronous reset clears control only; the RAMs need no clearing.
// ----------------------------------------------------------------------------
module roc_auc_trapezoid_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [rat_pkg::ScoreW-1:0] in_score,
  input  logic                           in_label,
  input  logic                           in_last,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [rat_pkg::AucW-1:0]       out_auc,
  output logic [rat_pkg::StatW-1:0]      out_status,
  output logic [rat_pkg::OutCntW-1:0]    out_positives,
  output logic [rat_pkg::OutCntW-1:0]    out_negatives
);
  import rat_pkg::*;
`include "roc_auc_trapezoid_core_assert.svh"

  typedef enum logic [10:0] {
    S_LOAD  = 11'b00000000001,
    S_COPY  = 11'b00000000010,
    S_HSEL  = 11'b00000000100,
    S_RDL   = 11'b00000001000,
    S_RDR   = 11'b00000010000,
    S_CMP   = 11'b00000100000,
    S_SWP   = 11'b00001000000,
    S_XTR   = 11'b00010000000,
    S_SWEEP = 11'b00100000000,
    S_DIV   = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;      // stored items
  logic            ovf_r, ovf_nxt;
  logic [CntW-1:0] pos_r, pos_nxt, neg_r, neg_nxt;
  logic [CntW-1:0] idx_r, idx_nxt;      // copy index / heap build index
  logic [CntW-1:0] hn_r, hn_nxt;        // heap size
  logic            bld_r, bld_nxt;      // build phase
  logic [CntW-1:0] root_r, root_nxt;
  logic [CntW-1:0] ch_r, ch_nxt;
  key_t            rk_r, rk_nxt, lk_r, lk_nxt, ck_r, ck_nxt;
  logic            rd1_r, rd1_nxt;      // second-step flag: read data pending or second write due
  logic [ScoreW-1:0] gkey_r, gkey_nxt;
  logic            gon_r, gon_nxt;
  logic [CntW-1:0] gp_r, gp_nxt, gn_r, gn_nxt, tp_r, tp_nxt;
  logic [SumW-1:0] sum_r, sum_nxt;
  logic [AucW-1:0] auc_r, auc_nxt;
  logic [StatW-1:0] st_r, st_nxt;
  logic            ov_r, ov_nxt;
  logic [2*CntW-1:0] pn_r;

  // store RAM
  logic              s_we;
  logic [AddrW-1:0]  s_ra;
  key_t              s_rd;
  // work RAM
  logic              w_we;
  logic [AddrW-1:0]  w_wa, w_ra;
  key_t              w_wd, w_rd;

  logic in_acc, out_acc, dv_start, dv_done;
  logic [SumW+16:0] dv_num, dv_quo;
  logic [SumW:0]    dv_den;
  logic [SumW+1:0]  gterm;
  key_t             in_key;

  assign in_key = {~in_score[ScoreW-1], in_score[ScoreW-2:0], in_label};

  rat_ram #(.Width(KeyW), .Depth(Capacity)) u_store (
    .clk(clk), .we(s_we), .waddr(cnt_r[AddrW-1:0]), .wdata(in_key),
    .raddr(s_ra), .rdata(s_rd));
  rat_ram #(.Width(KeyW), .Depth(Capacity)) u_work (
    .clk(clk), .we(w_we), .waddr(w_wa), .wdata(w_wd),
    .raddr(w_ra), .rdata(w_rd));

  // hold the input while a result waits so its payload stays put
  assign in_stall = (state_r != S_LOAD) || ov_r;
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = ov_r && !out_stall;
  assign s_we     = in_acc && (cnt_r != CntW'(Capacity));
  assign s_ra     = idx_r[AddrW-1:0];

  always_ff @(posedge clk) pn_r <= pos_r * neg_r;

  assign dv_num = {sum_r, 16'd0} + (SumW+17)'(pn_r);
  assign dv_den = {1'b0, pn_r, 1'b0};
  assign gterm  = (SumW+2)'(gn_r) * (SumW+2)'({tp_r, 1'b0} + gp_r);

  rat_div u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .num(dv_num), .den(dv_den),
    .done(dv_done), .quo(dv_quo));

  always_comb begin
    state_nxt = state_r; cnt_nxt = cnt_r; ovf_nxt = ovf_r;
    pos_nxt = pos_r; neg_nxt = neg_r; idx_nxt = idx_r; hn_nxt = hn_r;
    bld_nxt = bld_r; root_nxt = root_r; ch_nxt = ch_r;
    rk_nxt = rk_r; lk_nxt = lk_r; ck_nxt = ck_r; rd1_nxt = 1'b0;
    gkey_nxt = gkey_r; gon_nxt = gon_r; gp_nxt = gp_r; gn_nxt = gn_r;
    tp_nxt = tp_r; sum_nxt = sum_r; auc_nxt = auc_r; st_nxt = st_r;
    ov_nxt = ov_r; dv_start = 1'b0;
    w_we = 1'b0; w_wa = '0; w_wd = s_rd; w_ra = '0;
    if (out_acc) ov_nxt = 1'b0;
    unique case (state_r)
      S_LOAD: if (in_acc) begin
        if (cnt_r != CntW'(Capacity)) cnt_nxt = cnt_r + 1'b1;
        else ovf_nxt = 1'b1;
        if (in_last) begin
          idx_nxt = '0; pos_nxt = '0; neg_nxt = '0;
          state_nxt = S_COPY;
        end
      end
      S_COPY: begin
        // store read issued at idx, data lands in the next cycle
        if (idx_r != '0) begin
          w_we = 1'b1; w_wa = AddrW'(idx_r - 1'b1); w_wd = s_rd;
          if (s_rd[0]) pos_nxt = pos_r + 1'b1; else neg_nxt = neg_r + 1'b1;
        end
        idx_nxt = idx_r + 1'b1;
        if (idx_r == cnt_r) begin
          hn_nxt = cnt_r; bld_nxt = 1'b1; idx_nxt = cnt_r >> 1;
          state_nxt = S_HSEL;
        end
      end
      S_HSEL: begin
        if (pos_r == '0 || neg_r == '0) begin
          auc_nxt = '0; st_nxt = ST_ONECLS; state_nxt = S_OUT;
        end else if (bld_r) begin
          if (idx_r == '0) begin
            bld_nxt = 1'b0;
          end else begin
            root_nxt = idx_r - 1'b1; idx_nxt = idx_r - 1'b1;
            state_nxt = S_RDL;
          end
        end else if (hn_r > CntW'(1)) begin
          state_nxt = S_XTR; w_ra = '0;
        end else begin
          idx_nxt = cnt_r; gon_nxt = 1'b0; tp_nxt = '0; sum_nxt = '0;
          gp_nxt = '0; gn_nxt = '0; state_nxt = S_SWEEP;
        end
      end
      S_XTR: begin
        // swap root with last heap entry, shrink heap
        w_ra = AddrW'(hn_r - 1'b1);
        if (rd1_r) begin
          w_we = 1'b1; w_wa = '0; w_wd = w_rd;
          hn_nxt = hn_r - 1'b1; root_nxt = '0; state_nxt = S_RDL;
        end else begin
          rk_nxt = w_rd; rd1_nxt = 1'b1;
          w_we = 1'b1; w_wa = AddrW'(hn_r - 1'b1); w_wd = w_rd;
        end
      end
      S_RDL: begin
        ch_nxt = {root_r[CntW-2:0], 1'b1};
        if ({root_r[CntW-2:0], 1'b1} >= hn_r) state_nxt = S_HSEL;
        else begin
          w_ra = root_r[AddrW-1:0];
          state_nxt = S_RDR;
        end
      end
      S_RDR: begin
        rk_nxt = w_rd;
        w_ra = ch_r[AddrW-1:0];
        state_nxt = S_CMP; rd1_nxt = 1'b1;
      end
      S_CMP: begin
        if (rd1_r) begin
          lk_nxt = w_rd; ck_nxt = w_rd;
          w_ra = AddrW'(ch_r + 1'b1);
          if (ch_r + 1'b1 >= hn_r) state_nxt = S_SWP;
        end else begin
          if (w_rd > lk_r) begin ck_nxt = w_rd; ch_nxt = ch_r + 1'b1; end
          state_nxt = S_SWP;
        end
      end
      S_SWP: begin
        if (rk_r >= ck_r) state_nxt = S_HSEL;
        else begin
          if (!rd1_r) begin
            w_we = 1'b1; w_wa = root_r[AddrW-1:0]; w_wd = ck_r; rd1_nxt = 1'b1;
          end else begin
            w_we = 1'b1; w_wa = ch_r[AddrW-1:0]; w_wd = rk_r;
            root_nxt = ch_r; state_nxt = S_RDL;
          end
        end
      end
      S_SWEEP: begin
        // read from the top (highest key) downwards
        if (rd1_r) begin
          if (gon_r && w_rd[KeyW-1:1] != gkey_r) begin
            sum_nxt = sum_r + SumW'(gterm);
            tp_nxt = tp_r + gp_r;
            gp_nxt = {{(CntW-1){1'b0}}, w_rd[0]};
            gn_nxt = {{(CntW-1){1'b0}}, ~w_rd[0]};
          end else begin
            if (w_rd[0]) gp_nxt = gp_r + 1'b1; else gn_nxt = gn_r + 1'b1;
          end
          gon_nxt = 1'b1; gkey_nxt = w_rd[KeyW-1:1];
        end else if (idx_r != '0) begin
          w_ra = AddrW'(idx_r - 1'b1); idx_nxt = idx_r - 1'b1; rd1_nxt = 1'b1;
        end else begin
          sum_nxt = sum_r + SumW'(gterm); gp_nxt = '0; gn_nxt = '0;
          state_nxt = S_DIV; rd1_nxt = 1'b1;
        end
      end
      S_DIV: begin
        dv_start = rd1_r;
        if (dv_done) begin
          auc_nxt = (dv_quo > (SumW+17)'(65536)) ? AucW'(65536) : AucW'(dv_quo);
          st_nxt = ovf_r ? ST_OVERFL : ST_OK;
          state_nxt = S_OUT;
        end
      end
      S_OUT: if (!ov_r) begin
        ov_nxt = 1'b1; cnt_nxt = '0; ovf_nxt = 1'b0; state_nxt = S_LOAD;
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD; cnt_r <= '0; ovf_r <= 1'b0; ov_r <= 1'b0; rd1_r <= 1'b0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; ovf_r <= ovf_nxt;
      ov_r <= ov_nxt; rd1_r <= rd1_nxt;
    end
    pos_r <= pos_nxt; neg_r <= neg_nxt; idx_r <= idx_nxt; hn_r <= hn_nxt;
    bld_r <= bld_nxt; root_r <= root_nxt; ch_r <= ch_nxt;
    rk_r <= rk_nxt; lk_r <= lk_nxt; ck_r <= ck_nxt;
    gkey_r <= gkey_nxt; gon_r <= gon_nxt; gp_r <= gp_nxt; gn_r <= gn_nxt;
    tp_r <= tp_nxt; sum_r <= sum_nxt; auc_r <= auc_nxt; st_r <= st_nxt;
  end

  assign out_valid     = ov_r;
  assign out_auc       = auc_r;
  assign out_status    = st_r;
  assign out_positives = OutCntW'(pos_r);
  assign out_negatives = OutCntW'(neg_r);

  `RAT_ASSERT_IMPL(a_cnt_cap, 1'b1, cnt_r <= CntW'(Capacity), "item count above capacity")
  `RAT_ASSERT_IMPL(a_auc_max, out_valid, out_auc <= AucW'(65536), "auc above one")
  `RAT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped")
endmodule

// ===== rtl/rat_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rat_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rat_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/rat_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rat_div
// Restoring divider: one quotient bit a cycle.
// ----------------------------------------------------------------------------
module rat_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [rat_pkg::SumW+16:0] num,
  input  logic [rat_pkg::SumW:0]  den,
  output logic                    done,
  output logic [rat_pkg::SumW+16:0] quo
);
  import rat_pkg::*;
  localparam int NW = SumW + 17;
  localparam int BW = $clog2(NW + 1);

  logic [NW-1:0]  q_r, q_nxt;
  logic [SumW+1:0] rem_r, rem_nxt;
  logic [SumW:0]  den_r;
  logic [BW-1:0]  cnt_r, cnt_nxt;
  logic           busy_r, busy_nxt, done_r, done_nxt;
  logic [SumW+1:0] trial;

  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    trial = {rem_r[SumW:0], q_r[NW-1]};
    if (start) begin
      q_nxt = num; rem_nxt = '0; cnt_nxt = BW'(NW); busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt = {q_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == BW'(1)) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt;
    end
    q_r <= q_nxt; rem_r <= rem_nxt; cnt_r <= cnt_nxt;
    if (start) den_r <= den;
  end

  assign done = done_r;
  assign quo  = q_r;
endmodule
